// ----- hw/rtl/pulse_interval_histogram_core_assert.svh -----
// Assertion macros shared by the histogram checker.
`ifndef PULSE_INTERVAL_HISTOGRAM_CORE_ASSERT_SVH
`define PULSE_INTERVAL_HISTOGRAM_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define PIH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define PIH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// checked at every edge, reset included
`define PIH_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

// ----- hw/rtl/pih_pkg.sv -----
// ----------------------------------------------------------------------------
// Pulse interval histogram package
// Shared widths, reset values, function codes and the queue entry type.
// ----------------------------------------------------------------------------
package pih_pkg;

    localparam int STAMP_W    = 32;
    localparam int COUNT_W    = 16;
    localparam int TOTAL_W    = 16;
    localparam int IDX_W      = 7;
    localparam int BIN_ADDR_W = 10;   // enough for up to 1024 bins
    localparam int CFG_ADDR_W = 3;

    localparam int BINS_DEFAULT        = 101;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [STAMP_W-1:0] LOWER_LIMIT_RESET = 32'd950;
    localparam logic [TOTAL_W-1:0] RUN_TARGET_RESET  = 16'd1000;
    localparam logic [COUNT_W-1:0] COUNT_MAX         = 16'hFFFF;

    // register index, taken from paddr[2]
    localparam logic REG_LOWER_LIMIT = 1'b0;
    localparam logic REG_RUN_TARGET  = 1'b1;

    typedef enum logic [1:0] {
        FUNC_CAPTURE = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_CLEAR   = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        OP_NOP   = 2'd0,
        OP_INC   = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_kind_t;

    typedef struct packed {
        op_kind_t               kind;
        logic [BIN_ADDR_W-1:0]  addr;
        logic                   accepted;
        logic [STAMP_W-1:0]     interval;
        logic                   done;
    } op_t;

endpackage

// ----- hw/rtl/pulse_interval_histogram_core.sv -----
// ----------------------------------------------------------------------------
// Pulse interval histogram core
// Bins capture-to-capture intervals into a saturating histogram, with bin
// reads, clear, and an APB register port for the window and run target.
// ----------------------------------------------------------------------------
// One result per item, in order, after the queue, the execute stage and the
// result register. One item per cycle is sustained while result_stall is
// low: the front end updates the interval, accepted total and done state as
// it takes each item, and the back end does one bin RAM read-modify-write per
// cycle, forwarding the last write around the registered RAM read. A queue
// of QUEUE_DEPTH operations sits between the two; item_stall rises only when
// it is full. The bin store needs no clearing pass: per-bin valid bits, reset
// at once by reset or a clear item, make untouched bins read as zero.
// Registers: lower_limit at 0x0, run_target at 0x4.
// ----------------------------------------------------------------------------
module pulse_interval_histogram_core
    import pih_pkg::*;
#(
    parameter int BINS        = BINS_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // items
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [1:0]            func,
    input  logic [STAMP_W-1:0]    timestamp,
    input  logic [IDX_W-1:0]      bin_index,
    // results
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [COUNT_W-1:0]    bin_count,
    output logic                  accepted,
    output logic [STAMP_W-1:0]    interval,
    output logic                  done_res,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [STAMP_W-1:0] lower_limit_reg;
    logic [TOTAL_W-1:0] run_target_reg;

    logic cfg_write;
    logic push;
    logic queue_full;
    logic queue_empty;
    logic pop;
    op_t  front_op;
    op_t  queue_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_limit_reg <= LOWER_LIMIT_RESET;
            run_target_reg  <= RUN_TARGET_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_LOWER_LIMIT: lower_limit_reg <= pwdata;
                REG_RUN_TARGET:  run_target_reg  <= pwdata[TOTAL_W-1:0];
                default:         lower_limit_reg <= lower_limit_reg;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_RUN_TARGET) ? 32'(run_target_reg) : lower_limit_reg;

    assign item_stall = queue_full;
    assign push       = item_valid && !queue_full;

    pih_front #(
        .BINS (BINS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .func        (func),
        .timestamp   (timestamp),
        .bin_index   (bin_index),
        .lower_limit (lower_limit_reg),
        .run_target  (run_target_reg),
        .op          (front_op)
    );

    pih_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_op),
        .pop       (pop),
        .head      (queue_head),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    pih_back #(
        .BINS (BINS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (queue_head),
        .empty        (queue_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .bin_count    (bin_count),
        .accepted     (accepted),
        .interval     (interval),
        .done_res     (done_res)
    );

endmodule

// ----- hw/rtl/pih_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pih_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 101
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/pih_fifo.sv -----
// ----------------------------------------------------------------------------
// Histogram operation queue
// Small FIFO of classified operations between the front and back parts.
// ----------------------------------------------------------------------------
module pih_fifo
    import pih_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_data,
    input  logic pop,
    output op_t  head,
    output logic full,
    output logic empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_t              entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

endmodule

// ----- hw/rtl/pih_front.sv -----
// ----------------------------------------------------------------------------
// Histogram front end
// Takes items, forms intervals, tracks the accepted total and done, and
// turns each item into one bin operation for the queue.
// ----------------------------------------------------------------------------
module pih_front
    import pih_pkg::*;
#(
    parameter int BINS = BINS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [1:0]         func,
    input  logic [STAMP_W-1:0] timestamp,
    input  logic [IDX_W-1:0]   bin_index,
    input  logic [STAMP_W-1:0] lower_limit,
    input  logic [TOTAL_W-1:0] run_target,
    output op_t                op
);

    localparam logic [STAMP_W-1:0] BINS_LIMIT = STAMP_W'(BINS);

    logic [STAMP_W-1:0] prev_stamp_reg;
    logic               have_prev_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic [STAMP_W-1:0] prev_stamp_next;
    logic               have_prev_next;
    logic [TOTAL_W-1:0] total_next;

    logic [STAMP_W-1:0] diff;
    logic [STAMP_W-1:0] offset;
    logic               in_window;
    logic               done_now;

    assign diff      = timestamp - prev_stamp_reg;
    assign offset    = diff - lower_limit;
    assign in_window = (diff >= lower_limit) && (offset < BINS_LIMIT);
    assign done_now  = (total_reg >= run_target);

    always_comb
    begin
        prev_stamp_next = prev_stamp_reg;
        have_prev_next  = have_prev_reg;
        total_next      = total_reg;
        op.kind         = OP_NOP;
        op.addr         = '0;
        op.accepted     = 1'b0;
        op.interval     = '0;
        case (func)
            FUNC_CAPTURE:
            begin
                if (!done_now)
                begin
                    prev_stamp_next = timestamp;
                    have_prev_next  = 1'b1;
                    if (have_prev_reg)
                    begin
                        op.interval = diff;
                        if (in_window)
                        begin
                            op.kind     = OP_INC;
                            op.addr     = offset[BIN_ADDR_W-1:0];
                            op.accepted = 1'b1;
                            total_next  = total_reg + 1'b1;
                        end
                    end
                end
            end
            FUNC_READ:
            begin
                if (STAMP_W'(bin_index) < BINS_LIMIT)
                begin
                    op.kind = OP_READ;
                    op.addr = BIN_ADDR_W'(bin_index);
                end
            end
            FUNC_CLEAR:
            begin
                op.kind        = OP_CLEAR;
                total_next     = '0;
                have_prev_next = 1'b0;
            end
            default:
            begin
                op.kind = OP_NOP;
            end
        endcase
        op.done = (total_next >= run_target);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            prev_stamp_reg <= prev_stamp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            total_reg     <= '0;
        end
        else if (push)
        begin
            have_prev_reg <= have_prev_next;
            total_reg     <= total_next;
        end
    end

endmodule

// ----- hw/rtl/pih_back.sv -----
// ----------------------------------------------------------------------------
// Histogram back end
// Runs queued bin operations against the bin RAM and drives the result
// register. Updates are read-modify-write with forwarding of the last write.
// ----------------------------------------------------------------------------
module pih_back
    import pih_pkg::*;
#(
    parameter int BINS = BINS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  op_t                head,
    input  logic               empty,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [COUNT_W-1:0] bin_count,
    output logic               accepted,
    output logic [STAMP_W-1:0] interval,
    output logic               done_res
);

    localparam int BIN_AW = $clog2(BINS);

    // execute stage
    logic               ex_valid_reg;
    op_t                ex_op_reg;
    // last bin write, forwarded over the RAM read latency
    logic               lw_valid_reg;
    logic [BIN_AW-1:0]  lw_addr_reg;
    logic [COUNT_W-1:0] lw_data_reg;
    // a bin not written since reset or clear reads as zero
    logic [BINS-1:0]    bin_valid_reg;
    // result register
    logic               out_valid_reg;
    logic [COUNT_W-1:0] bin_count_reg;
    logic               accepted_reg;
    logic [STAMP_W-1:0] interval_reg;
    logic               done_reg;

    logic               advance;
    logic [BIN_AW-1:0]  ex_addr;
    logic [COUNT_W-1:0] ram_rdata;
    logic [COUNT_W-1:0] old_count;
    logic [COUNT_W-1:0] new_count;
    logic               bin_write;

    assign advance   = !out_valid_reg || !result_stall;
    assign pop       = advance && !empty;
    assign ex_addr   = ex_op_reg.addr[BIN_AW-1:0];
    assign bin_write = advance && ex_valid_reg && (ex_op_reg.kind == OP_INC);

    always_comb
    begin
        if (!bin_valid_reg[ex_addr])
        begin
            old_count = '0;
        end
        else if (lw_valid_reg && (lw_addr_reg == ex_addr))
        begin
            old_count = lw_data_reg;
        end
        else
        begin
            old_count = ram_rdata;
        end
        new_count = (old_count == COUNT_MAX) ? old_count : old_count + 1'b1;
    end

    pih_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (BINS)
    ) u_bin_ram (
        .clk   (clk),
        .we    (bin_write),
        .waddr (ex_addr),
        .wdata (new_count),
        .re    (advance),
        .raddr (head.addr[BIN_AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ex_op_reg <= head;
            if (bin_write)
            begin
                lw_addr_reg <= ex_addr;
                lw_data_reg <= new_count;
            end
            if (ex_valid_reg)
            begin
                bin_count_reg <= (ex_op_reg.kind == OP_READ) ? old_count : '0;
                accepted_reg  <= ex_op_reg.accepted;
                interval_reg  <= ex_op_reg.interval;
                done_reg      <= ex_op_reg.done;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg  <= 1'b0;
            lw_valid_reg  <= 1'b0;
            bin_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            ex_valid_reg  <= !empty;
            out_valid_reg <= ex_valid_reg;
            if (ex_valid_reg && (ex_op_reg.kind == OP_CLEAR))
            begin
                bin_valid_reg <= '0;
                lw_valid_reg  <= 1'b0;
            end
            else if (bin_write)
            begin
                bin_valid_reg[ex_addr] <= 1'b1;
                lw_valid_reg           <= 1'b1;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign bin_count    = bin_count_reg;
    assign accepted     = accepted_reg;
    assign interval     = interval_reg;
    assign done_res     = done_reg;

endmodule

// ----- hw/rtl/pih_checker.sv -----
// ----------------------------------------------------------------------------
// Histogram port checker
// Port-level assertions on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`include "pulse_interval_histogram_core_assert.svh"

module pih_checker
    import pih_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               result_valid,
    input  logic               result_stall,
    input  logic [COUNT_W-1:0] bin_count,
    input  logic               accepted,
    input  logic [STAMP_W-1:0] interval,
    input  logic               done_res
);

    // a stalled result holds
    `PIH_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable({bin_count, accepted, interval, done_res}), "stalled result changed")

    // only reads report a count, only captures report acceptance
    `PIH_ASSERT_NOW(a_read_or_capture, result_valid && (bin_count != '0), !accepted && (interval == '0), "bin count on a capture transfer")

    // nothing comes out of reset
    `PIH_ASSERT_ALWAYS(a_reset_quiet, rst_n || !result_valid, "result valid during reset")

endmodule

bind pulse_interval_histogram_core pih_checker u_pih_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .bin_count    (bin_count),
    .accepted     (accepted),
    .interval     (interval),
    .done_res     (done_res)
);
